// File: src/srld_pkg.sv
// Package for the sprite run-length line decoder.
// Holds shared types, codes, sizes and the glow ramp table; no dependencies.
package srld_pkg;

   // Fixed sizes
   localparam int MaxDim       = 4096;
   localparam int PaletteDepth = 256;
   localparam int JobDepth     = 4;
   localparam int RspDepth     = 4;
   localparam logic [23:0] KeyColor = 24'hFF00FF;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_CELL_WIDTH   = 2'd0,
      CSR_CELL_HEIGHT  = 2'd1,
      CSR_COLUMN_MAJOR = 2'd2,
      CSR_GLOW_ENABLE  = 2'd3
   } csr_index_type;

   // Input item kinds
   localparam logic KindPalette = 1'b0;
   localparam logic KindCode    = 1'b1;

   // Parser modes
   typedef enum logic [1:0] {
      MODE_CTRL = 2'd0,
      MODE_FILL = 2'd1,
      MODE_LIT  = 2'd2
   } parse_mode_type;

   // Work handed from the parser to the back end
   typedef struct packed {
      logic        is_write;
      logic        use_glow;
      logic [7:0]  addr;
      logic [23:0] rgb;
      logic [11:0] x_start;
      logic [11:0] y_start;
      logic [7:0]  run_length;
   } job_type;

   // One finished run descriptor
   typedef struct packed {
      logic [11:0] x_start;
      logic [11:0] y_start;
      logic [7:0]  run_length;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
   } rsp_type;

   // Glow ramp: red 255, other channels are the truncated ramp values
   function automatic logic [31:0] glow_rgba(input logic [3:0] idx);
      logic [31:0] c;
      case (idx)
         4'd1:    c = {8'd255, 8'd147, 8'd52,  8'd53};
         4'd2:    c = {8'd255, 8'd155, 8'd65,  8'd67};
         4'd3:    c = {8'd255, 8'd163, 8'd78,  8'd81};
         4'd4:    c = {8'd255, 8'd170, 8'd90,  8'd94};
         4'd5:    c = {8'd255, 8'd178, 8'd103, 8'd108};
         4'd6:    c = {8'd255, 8'd186, 8'd116, 8'd122};
         4'd7:    c = {8'd255, 8'd193, 8'd128, 8'd135};
         4'd8:    c = {8'd255, 8'd201, 8'd141, 8'd149};
         4'd9:    c = {8'd255, 8'd209, 8'd154, 8'd163};
         4'd10:   c = {8'd255, 8'd216, 8'd166, 8'd176};
         4'd11:   c = {8'd255, 8'd224, 8'd179, 8'd190};
         4'd12:   c = {8'd255, 8'd232, 8'd192, 8'd204};
         4'd13:   c = {8'd255, 8'd239, 8'd204, 8'd217};
         4'd14:   c = {8'd255, 8'd247, 8'd217, 8'd231};
         4'd15:   c = {8'd255, 8'd255, 8'd230, 8'd245};
         default: c = {8'd255, 8'd140, 8'd40,  8'd40};
      endcase
      return c;
   endfunction

endpackage

// File: src/sprite_rle_line_decoder_top.sv
// Top level of the sprite run-length line decoder.
// Uses srld_pkg, srld_front, srld_queue and srld_back.

// Decodes run-length coded palette sprite lines into run descriptors. Each
// accepted item is either a palette entry write or one coded byte; the parser
// takes one item per clock while req_full is low, and every item yields at
// most one descriptor, so the sustained rate is one item per cycle with both
// sides flowing. A visible run passes the job queue, the registered palette
// read and the mapping stage that writes the result queue before it reaches
// the result ports. The rate is set by the parser and the one palette port,
// which serves a write or a read per cycle. Four-entry queues sit after the
// parser and at the result side; full rises only when the job queue backs
// up. Palette entries must be written before they are used. Configure only
// while idle.
module sprite_rle_line_decoder_top
   import srld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data,
   // input items
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_kind,
   input  logic [11:0] req_line_index,
   input  logic        req_first_in_line,
   input  logic [7:0]  req_code_byte,
   input  logic [7:0]  req_pal_index,
   input  logic [7:0]  req_pal_red,
   input  logic [7:0]  req_pal_green,
   input  logic [7:0]  req_pal_blue,
   // results
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [11:0] rsp_x_start,
   output logic [11:0] rsp_y_start,
   output logic [7:0]  rsp_run_length,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha
);

   localparam int JobCntW = $clog2(JobDepth+1);

   logic               accept;
   logic               job_push;
   job_type            job_in;
   logic [$bits(job_type)-1:0] job_raw;
   logic               job_pop;
   logic               job_empty;
   logic               job_full;
   logic [JobCntW-1:0] job_count;
   rsp_type            rsp_head;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;

   srld_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .accept        (accept),
      .kind          (req_kind),
      .line_index    (req_line_index),
      .first_in_line (req_first_in_line),
      .code_byte     (req_code_byte),
      .pal_index     (req_pal_index),
      .pal_red       (req_pal_red),
      .pal_green     (req_pal_green),
      .pal_blue      (req_pal_blue),
      .job_push      (job_push),
      .job_data      (job_in)
   );

   srld_queue #(
      .WIDTH ($bits(job_type)),
      .DEPTH (JobDepth)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .pop_data  (job_raw),
      .empty     (job_empty),
      .full      (job_full),
      .count     (job_count)
   );

   srld_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_head  (job_type'(job_raw)),
      .job_pop   (job_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_head  (rsp_head)
   );

   // Occupancy of the job queue is only needed inside the queue
   logic unused_count;
   assign unused_count = ^job_count;

   assign rsp_x_start    = rsp_head.x_start;
   assign rsp_y_start    = rsp_head.y_start;
   assign rsp_run_length = rsp_head.run_length;
   assign rsp_red        = rsp_head.red;
   assign rsp_green      = rsp_head.green;
   assign rsp_blue       = rsp_head.blue;
   assign rsp_alpha      = rsp_head.alpha;

endmodule

// File: src/srld_queue.sv
// Small register-based FIFO used between decoder stages.
// Stand-alone; no package dependency.
module srld_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic                       full,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push  = push && (count_ff != CntW'(DEPTH));
   assign do_pop   = pop && (count_ff != '0);
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CntW'(DEPTH));
   assign count    = count_ff;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? PtrW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PtrW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CntW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CntW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/srld_front.sv
// Front end: configuration registers and the run-length parser.
// Uses srld_pkg; emits palette writes and visible run candidates as jobs.
module srld_front
   import srld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data,
   input  logic        accept,
   input  logic        kind,
   input  logic [11:0] line_index,
   input  logic        first_in_line,
   input  logic [7:0]  code_byte,
   input  logic [7:0]  pal_index,
   input  logic [7:0]  pal_red,
   input  logic [7:0]  pal_green,
   input  logic [7:0]  pal_blue,
   output logic        job_push,
   output job_type     job_data
);

   logic [12:0]    cell_width_ff;
   logic [12:0]    cell_height_ff;
   logic           column_major_ff;
   logic           glow_enable_ff;

   parse_mode_type mode_ff, mode_in;
   logic [12:0]    pos_ff, pos_in;
   logic [7:0]     rem_ff, rem_in;
   logic [11:0]    line_ff, line_in;

   parse_mode_type mode_cur;
   logic [12:0]    pos_cur;
   logic [7:0]     rem_cur;
   logic [11:0]    line_cur;
   logic [12:0]    span;
   logic [12:0]    avail;
   logic [7:0]     ctrl_count;
   logic [7:0]     rem_dec;
   logic           emit;
   logic [7:0]     emit_len;
   logic           cell_ok;
   logic [12:0]    px, py;
   logic           in_cell;

   assign csr_ready = 1'b1;

   // Hold configuration; unknown indexes cannot occur with a two-bit index
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_width_ff   <= 13'd1;
         cell_height_ff  <= 13'd1;
         column_major_ff <= 1'b0;
         glow_enable_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_CELL_WIDTH:   cell_width_ff   <= csr_data;
            CSR_CELL_HEIGHT:  cell_height_ff  <= csr_data;
            CSR_COLUMN_MAJOR: column_major_ff <= csr_data[0];
            CSR_GLOW_ENABLE:  glow_enable_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Parser state register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CTRL;
         pos_ff  <= '0;
         rem_ff  <= '0;
         line_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         rem_ff  <= rem_in;
         line_ff <= line_in;
      end
   end

   // Next parser state and run candidate
   always_comb begin
      mode_cur   = first_in_line ? MODE_CTRL : mode_ff;
      pos_cur    = first_in_line ? 13'd0 : pos_ff;
      rem_cur    = first_in_line ? 8'd0 : rem_ff;
      line_cur   = first_in_line ? line_index : line_ff;
      span       = column_major_ff ? cell_height_ff : cell_width_ff;
      avail      = span - pos_cur;
      ctrl_count = {1'b0, code_byte[7:1]} + 8'd1;
      rem_dec    = rem_cur - 8'd1;

      mode_in  = mode_ff;
      pos_in   = pos_ff;
      rem_in   = rem_ff;
      line_in  = line_ff;
      emit     = 1'b0;
      emit_len = 8'd1;

      if (accept && kind == KindCode) begin
         line_in = line_cur;
         pos_in  = pos_cur;
         rem_in  = rem_cur;
         mode_in = mode_cur;
         case (mode_cur)
            MODE_FILL: begin
               emit     = 1'b1;
               emit_len = rem_cur;
               pos_in   = pos_cur + {5'd0, rem_cur};
               rem_in   = 8'd0;
               mode_in  = MODE_CTRL;
            end
            MODE_LIT: begin
               emit     = 1'b1;
               emit_len = 8'd1;
               pos_in   = pos_cur + 13'd1;
               rem_in   = rem_dec;
               mode_in  = (rem_dec == 8'd0) ? MODE_CTRL : MODE_LIT;
            end
            default: begin
               mode_in = MODE_CTRL;
               if (pos_cur < span) begin
                  // Clip the run at the line end
                  if ({5'd0, ctrl_count} > avail) begin
                     rem_in = avail[7:0];
                  end else begin
                     rem_in = ctrl_count;
                  end
                  mode_in = code_byte[0] ? MODE_FILL : MODE_LIT;
               end
            end
         endcase
      end
   end

   // Drop runs outside the cell or in an invalid cell, and runs transparent by index
   always_comb begin
      cell_ok = (cell_width_ff != 13'd0) && (cell_height_ff != 13'd0) &&
                (cell_width_ff <= 13'(MaxDim)) && (cell_height_ff <= 13'(MaxDim));
      px      = column_major_ff ? {1'b0, line_cur} : pos_cur;
      py      = column_major_ff ? pos_cur : {1'b0, line_cur};
      in_cell = (px < cell_width_ff) && (py < cell_height_ff);

      job_data.is_write   = (kind == KindPalette);
      job_data.use_glow   = glow_enable_ff && (code_byte[7:4] == 4'd0);
      job_data.addr       = (kind == KindPalette) ? pal_index : code_byte;
      job_data.rgb        = {pal_red, pal_green, pal_blue};
      job_data.x_start    = px[11:0];
      job_data.y_start    = py[11:0];
      job_data.run_length = emit_len;

      job_push = accept && ((kind == KindPalette) ||
                 (emit && cell_ok && in_cell && (code_byte != 8'd0)));
   end

endmodule

// File: src/srld_back.sv
// Back end: palette memory, color mapping and the result queue.
// Uses srld_pkg and srld_queue; consumes jobs in order.
module srld_back
   import srld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_empty,
   input  job_type job_head,
   output logic    job_pop,
   input  logic    rsp_pop,
   output logic    rsp_empty,
   output rsp_type rsp_head
);

   localparam int RspCntW = $clog2(RspDepth+1);

   logic [23:0]        palette_mem [PaletteDepth];
   logic [23:0]        rd_data_ff;
   logic               s2_valid_ff, s2_valid_in;
   job_type            s2_job_ff;
   logic [RspCntW-1:0] rsp_count;
   logic               rsp_full;
   logic               issue;
   logic               visible;
   logic [31:0]        rgba;
   rsp_type            rsp_new;
   logic [$bits(rsp_type)-1:0] rsp_raw;

   // Issue a job only when the result queue has room for what is in flight
   assign issue = !job_empty &&
                  ((RspCntW+1)'(rsp_count) + (RspCntW+1)'(s2_valid_ff) <
                   (RspCntW+1)'(RspDepth));
   assign job_pop     = issue;
   assign s2_valid_in = issue && !job_head.is_write;

   // Write or read the palette, read data registered
   always_ff @(posedge clock) begin
      if (issue && job_head.is_write) begin
         palette_mem[job_head.addr] <= job_head.rgb;
      end
      rd_data_ff <= palette_mem[job_head.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_job_ff <= job_head;
   end

   // Map to RGBA; drop the magenta key for palette colors, glow colors always pass
   always_comb begin
      if (s2_job_ff.use_glow) begin
         rgba    = glow_rgba(s2_job_ff.addr[3:0]);
         visible = 1'b1;
      end else begin
         rgba    = {rd_data_ff, 8'd255};
         visible = (rd_data_ff != KeyColor);
      end
      rsp_new.x_start    = s2_job_ff.x_start;
      rsp_new.y_start    = s2_job_ff.y_start;
      rsp_new.run_length = s2_job_ff.run_length;
      rsp_new.red        = rgba[31:24];
      rsp_new.green      = rgba[23:16];
      rsp_new.blue       = rgba[15:8];
      rsp_new.alpha      = rgba[7:0];
   end

   srld_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RspDepth)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff && visible),
      .push_data (rsp_new),
      .pop       (rsp_pop),
      .pop_data  (rsp_raw),
      .empty     (rsp_empty),
      .full      (rsp_full),
      .count     (rsp_count)
   );

   assign rsp_head = rsp_type'(rsp_raw);

   // Credit check keeps the queue from overflowing; full only guards pushes
   logic unused_full;
   assign unused_full = rsp_full;

endmodule

// File: tb/tb.sv
// Testbench for sprite_rle_line_decoder_top: drives palette writes and coded line bytes,
// predicts the run descriptors in a small scoreboard class and checks them in order.
// Depends on srld_pkg and the decoder RTL.
module tb
   import srld_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GlowLimit   = 16;
   localparam int SettleTicks = 8;
   localparam int IdleLimit   = 2000;
   localparam int PhaseBeats  = 195;
   localparam int RandPhases  = 9;

   // One input beat as the sender sees it
   typedef struct {
      logic        kind;
      logic [11:0] line_index;
      logic        first_in_line;
      logic [7:0]  code_byte;
      logic [7:0]  pal_index;
      logic [23:0] pal_rgb;
   } req_beat_type;

   // Line decoder predictor and queue of expected run descriptors
   class descriptor_scoreboard;
      logic [23:0]    palette [PaletteDepth];
      bit             loaded [PaletteDepth];
      logic [7:0]     loaded_q [$];
      logic [12:0]    cell_width;
      logic [12:0]    cell_height;
      logic           column_major;
      logic           glow_enable;
      logic [12:0]    run_pos;
      parse_mode_type mode;
      logic [7:0]     run_left;
      logic [11:0]    line_num;
      rsp_type        expected_runs [$];
      int             mismatches;
      int             beats_in;
      int             runs_out;

      function void clear();
         foreach (loaded[i]) loaded[i] = 1'b0;
         loaded_q.delete();
         expected_runs.delete();
         cell_width   = 13'd1;
         cell_height  = 13'd1;
         column_major = 1'b0;
         glow_enable  = 1'b0;
         run_pos      = '0;
         mode         = MODE_CTRL;
         run_left     = '0;
         line_num     = '0;
         mismatches   = 0;
         beats_in     = 0;
         runs_out     = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [12:0] value);
         case (idx)
            CSR_CELL_WIDTH:   cell_width   = value;
            CSR_CELL_HEIGHT:  cell_height  = value;
            CSR_COLUMN_MAJOR: column_major = value[0];
            CSR_GLOW_ENABLE:  glow_enable  = value[0];
            default: ;
         endcase
      endfunction

      function logic [12:0] span();
         return column_major ? cell_height : cell_width;
      endfunction

      // Parser waits for a control byte but the line has no room left
      function bit line_full();
         return mode == MODE_CTRL && run_pos >= span();
      endfunction

      function bit wants_index();
         return mode != MODE_CTRL;
      endfunction

      function int pending();
         return expected_runs.size();
      endfunction

      // Map an index and queue a descriptor for a visible pixel inside the cell
      function void add_run(logic [7:0] idx, logic [7:0] len);
         logic [23:0] rgb;
         logic [7:0]  a;
         logic [12:0] px;
         logic [12:0] py;
         rsp_type     r;
         if (cell_width == 0 || cell_height == 0 || cell_width > MaxDim ||
             cell_height > MaxDim || idx == 0) return;
         if (glow_enable && idx < GlowLimit) begin
            rgb = {8'd255, 8'(140 + 115 * idx / 15), 8'(40 + 190 * idx / 15)};
            a   = 8'(40 + 205 * idx / 15);
         end else begin
            rgb = palette[idx];
            a   = 8'd255;
            if (rgb == KeyColor) return;
         end
         px = column_major ? {1'b0, line_num} : run_pos;
         py = column_major ? run_pos : {1'b0, line_num};
         if (px >= cell_width || py >= cell_height) return;
         r.x_start    = px[11:0];
         r.y_start    = py[11:0];
         r.run_length = len;
         r.red        = rgb[23:16];
         r.green      = rgb[15:8];
         r.blue       = rgb[7:0];
         r.alpha      = a;
         expected_runs.push_back(r);
      endfunction

      // Advance the parser by one accepted beat
      function void note_beat(req_beat_type b);
         int count;
         beats_in++;
         if (b.kind == KindPalette) begin
            if (!loaded[b.pal_index]) begin
               loaded[b.pal_index] = 1'b1;
               loaded_q.push_back(b.pal_index);
            end
            palette[b.pal_index] = b.pal_rgb;
            return;
         end
         if (b.first_in_line) begin
            line_num = b.line_index;
            run_pos  = '0;
            mode     = MODE_CTRL;
            run_left = '0;
         end
         case (mode)
            MODE_FILL: begin
               add_run(b.code_byte, run_left);
               run_pos  = run_pos + {5'd0, run_left};
               run_left = '0;
               mode     = MODE_CTRL;
            end
            MODE_LIT: begin
               add_run(b.code_byte, 8'd1);
               run_pos  = run_pos + 13'd1;
               run_left = run_left - 8'd1;
               if (run_left == 0) mode = MODE_CTRL;
            end
            default: begin
               mode = MODE_CTRL;
               // start a run, clipped at the line end
               if (run_pos < span()) begin
                  count = int'(b.code_byte[7:1]) + 1;
                  if (count > int'(span() - run_pos)) count = int'(span() - run_pos);
                  run_left = 8'(count);
                  mode     = b.code_byte[0] ? MODE_FILL : MODE_LIT;
               end
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("ERROR: %s", msg);
      endtask

      task compare_field(string name, logic [11:0] got, logic [11:0] want);
         if (got !== want)
            report_mismatch($sformatf("run %0d %s: got %0h, expected %0h",
                                      runs_out, name, got, want));
      endtask

      // Compare one popped descriptor with the oldest expectation
      task check_run(rsp_type got);
         rsp_type want;
         if (expected_runs.size() == 0) begin
            report_mismatch($sformatf("run with nothing expected at x=%0d y=%0d",
                                      got.x_start, got.y_start));
            return;
         end
         want = expected_runs.pop_front();
         runs_out++;
         compare_field("x_start", got.x_start, want.x_start);
         compare_field("y_start", got.y_start, want.y_start);
         compare_field("run_length", 12'(got.run_length), 12'(want.run_length));
         compare_field("red", 12'(got.red), 12'(want.red));
         compare_field("green", 12'(got.green), 12'(want.green));
         compare_field("blue", 12'(got.blue), 12'(want.blue));
         compare_field("alpha", 12'(got.alpha), 12'(want.alpha));
      endtask
   endclass

   logic          clock;
   logic          reset;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [12:0]   csr_data;
   logic          req_push;
   logic          req_full;
   logic          req_kind;
   logic [11:0]   req_line_index;
   logic          req_first_in_line;
   logic [7:0]    req_code_byte;
   logic [7:0]    req_pal_index;
   logic [7:0]    req_pal_red;
   logic [7:0]    req_pal_green;
   logic [7:0]    req_pal_blue;
   logic          rsp_empty;
   logic          rsp_pop;
   logic [11:0]   rsp_x_start;
   logic [11:0]   rsp_y_start;
   logic [7:0]    rsp_run_length;
   logic [7:0]    rsp_red;
   logic [7:0]    rsp_green;
   logic [7:0]    rsp_blue;
   logic [7:0]    rsp_alpha;

   descriptor_scoreboard sb;
   int send_calm;
   int recv_calm;
   int cell_settings;
   int idle_cycles;

   sprite_rle_line_decoder_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_kind          (req_kind),
      .req_line_index    (req_line_index),
      .req_first_in_line (req_first_in_line),
      .req_code_byte     (req_code_byte),
      .req_pal_index     (req_pal_index),
      .req_pal_red       (req_pal_red),
      .req_pal_green     (req_pal_green),
      .req_pal_blue      (req_pal_blue),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_x_start       (rsp_x_start),
      .rsp_y_start       (rsp_y_start),
      .rsp_run_length    (rsp_run_length),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Draw a wait in cycles; now and then hold a calm stretch with no waits
   function automatic int next_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) begin
         calm = $urandom_range(8, 48);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   function automatic req_beat_type random_beat();
      req_beat_type b;
      b.kind          = 1'($urandom);
      b.line_index    = 12'($urandom);
      b.first_in_line = 1'($urandom);
      b.code_byte     = 8'($urandom);
      b.pal_index     = 8'($urandom);
      b.pal_rgb       = 24'($urandom);
      return b;
   endfunction

   // Control byte, half of them with short runs
   function automatic logic [7:0] random_ctrl();
      logic [7:0] c;
      c = 8'($urandom);
      if ($urandom_range(0, 1) != 0) c[7:1] = 7'($urandom_range(0, 7));
      return c;
   endfunction

   // Pixel index that never reads a palette entry left unwritten
   function automatic logic [7:0] pick_index();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) return 8'd0;
      if (roll < 35 && sb.glow_enable) return 8'($urandom_range(1, GlowLimit - 1));
      return sb.loaded_q[$urandom_range(0, sb.loaded_q.size() - 1)];
   endfunction

   // Drive one beat and hold it until the block takes it
   task automatic push_beat(input req_beat_type b);
      int gap;
      gap = next_wait(send_calm);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push          <= 1'b1;
      req_kind          <= b.kind;
      req_line_index    <= b.line_index;
      req_first_in_line <= b.first_in_line;
      req_code_byte     <= b.code_byte;
      req_pal_index     <= b.pal_index;
      req_pal_red       <= b.pal_rgb[23:16];
      req_pal_green     <= b.pal_rgb[15:8];
      req_pal_blue      <= b.pal_rgb[7:0];
      do @(posedge clock); while (req_full !== 1'b0);
      sb.note_beat(b);
   endtask

   task automatic send_pal(input logic [7:0] idx, input logic [23:0] rgb);
      req_beat_type b;
      b           = random_beat();
      b.kind      = KindPalette;
      b.pal_index = idx;
      b.pal_rgb   = rgb;
      push_beat(b);
   endtask

   task automatic send_code(input logic first, input logic [11:0] line,
                            input logic [7:0] code);
      req_beat_type b;
      b               = random_beat();
      b.kind          = KindCode;
      b.first_in_line = first;
      b.line_index    = line;
      b.code_byte     = code;
      push_beat(b);
   endtask

   // Stop sending, wait out every expected run, then let the pipeline settle
   task automatic drain();
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleTicks) @(posedge clock);
   endtask

   // Write all four registers back to back; only called while idle
   task automatic write_cell_config(input logic [12:0] w, input logic [12:0] h,
                                    input logic cm, input logic glow);
      csr_index_type regs [4];
      logic [12:0]   vals [4];
      regs = '{CSR_CELL_WIDTH, CSR_CELL_HEIGHT, CSR_COLUMN_MAJOR, CSR_GLOW_ENABLE};
      vals = '{w, h, {12'($urandom), cm}, {12'($urandom), glow}};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (csr_ready !== 1'b1);
         sb.set_reg(regs[i], vals[i]);
      end
      csr_valid <= 1'b0;
      cell_settings++;
   endtask

   task automatic run_directed();
      // reset settings: 1x1 cell, row major, glow off; load a few entries
      send_pal(8'h01, 24'h123456);
      send_pal(8'hFF, 24'hFFFFFF);
      send_pal(8'h80, KeyColor);
      send_pal(8'h00, 24'h000000);
      // bytes before any line start go to line 0; fill of 128 clipped to 1
      send_code(1'b0, 12'hABC, 8'hFF);
      send_code(1'b0, 12'h000, 8'hFF);
      // line already full: ignored
      send_code(1'b0, 12'hFFF, 8'h00);
      drain();

      // largest cell with glow: literal run of 128 on the last row
      write_cell_config(13'd4096, 13'd4096, 1'b0, 1'b1);
      send_code(1'b1, 12'hFFF, 8'hFE);
      send_code(1'b0, 12'h000, 8'h01);
      send_code(1'b0, 12'h000, 8'h0F);
      send_code(1'b0, 12'h000, 8'h80);
      send_code(1'b0, 12'h000, 8'h00);
      // palette write inside a literal run leaves the parser alone
      send_pal(8'h10, 24'h00FF00);
      send_code(1'b0, 12'h000, 8'h10);
      // restart mid run with a fill of two
      send_code(1'b1, 12'd7, 8'h03);
      send_code(1'b0, 12'h000, 8'h05);
      drain();

      // column major, short column: literal of 5 clipped to 3
      write_cell_config(13'd4096, 13'd3, 1'b1, 1'b0);
      send_code(1'b1, 12'd4000, 8'h08);
      send_code(1'b0, 12'h000, 8'h01);
      send_code(1'b0, 12'h000, 8'hFF);
      send_code(1'b0, 12'h000, 8'h01);
      send_code(1'b0, 12'h000, 8'h02);
      drain();

      // degenerate cell: parsed, nothing comes out
      write_cell_config(13'd0, 13'd8, 1'b1, 1'b1);
      send_code(1'b1, 12'd1, 8'h01);
      send_code(1'b0, 12'h000, 8'h05);
      drain();

      // row outside the cell, then a full-width fill on the last row
      write_cell_config(13'd8, 13'd2, 1'b0, 1'b0);
      send_code(1'b1, 12'd2, 8'h03);
      send_code(1'b0, 12'h000, 8'hFF);
      send_code(1'b1, 12'd1, 8'h0F);
      send_code(1'b0, 12'h000, 8'h01);
      drain();
   endtask

   // Mostly well-formed lines with random content, some noise and broken lines
   task automatic random_phase(input int quota);
      req_beat_type b;
      int           done;
      int           lines;
      bit           counts;
      done = 0;
      while (done < quota) begin
         b = random_beat();
         if ($urandom_range(0, 99) < 7) begin
            b.kind = KindPalette;
            if ($urandom_range(0, 7) == 0) b.pal_rgb = KeyColor;
         end else begin
            b.kind = KindCode;
            b.first_in_line = sb.line_full() ? ($urandom_range(0, 9) != 0)
                                             : ($urandom_range(0, 99) < 2);
            if (b.first_in_line) begin
               lines = int'(sb.column_major ? sb.cell_width : sb.cell_height);
               if (lines > 0 && lines <= MaxDim && $urandom_range(0, 3) != 0)
                  b.line_index = 12'($urandom_range(0, lines - 1));
               b.code_byte = random_ctrl();
            end else begin
               b.code_byte = sb.wants_index() ? pick_index() : random_ctrl();
            end
         end
         counts = !(b.kind == KindCode && !b.first_in_line && sb.line_full());
         push_beat(b);
         if (counts) done++;
         // hold the sender once per phase until every run is out
         if (counts && done == quota / 2) drain();
      end
   endtask

   // Pop descriptors with random stalls and check each one
   initial begin
      rsp_type got;
      int      stall;
      rsp_pop = 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = next_wait(recv_calm);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty !== 1'b0);
         got.x_start    = rsp_x_start;
         got.y_start    = rsp_y_start;
         got.run_length = rsp_run_length;
         got.red        = rsp_red;
         got.green      = rsp_green;
         got.blue       = rsp_blue;
         got.alpha      = rsp_alpha;
         sb.check_run(got);
      end
   end

   // End the run when no beat moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
         $display("Timed out after %0d cycles without a beat", IdleLimit);
         $display("Mismatches found");
         $finish;
      end
   end

   // Reset, directed beats, then random phases over several cell settings
   initial begin
      logic [12:0] w;
      logic [12:0] h;
      logic        cm;
      logic        g;
      reset             = 1'b1;
      csr_valid         = 1'b0;
      csr_index         = CSR_CELL_WIDTH;
      csr_data          = '0;
      req_push          = 1'b0;
      req_kind          = KindCode;
      req_line_index    = '0;
      req_first_in_line = 1'b0;
      req_code_byte     = '0;
      req_pal_index     = '0;
      req_pal_red       = '0;
      req_pal_green     = '0;
      req_pal_blue      = '0;
      send_calm         = 0;
      recv_calm         = 0;
      cell_settings     = 0;
      idle_cycles       = 0;
      sb = new();
      sb.clear();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      for (int p = 0; p < RandPhases; p++) begin
         case (p)
            0: begin w = 13'd16;   h = 13'd16;   cm = 1'b0; g = 1'b1; end
            1: begin w = 13'd4096; h = 13'd4096; cm = 1'b1; g = 1'b0; end
            2: begin w = 13'd1;    h = 13'd1;    cm = 1'b0; g = 1'b1; end
            3: begin w = 13'd4096; h = 13'd1;    cm = 1'b0; g = 1'b0; end
            4: begin w = 13'd8191; h = 13'd12;   cm = 1'b1; g = 1'b1; end
            default: begin
               w  = 13'($urandom_range(1, 48));
               h  = 13'($urandom_range(1, 48));
               cm = 1'($urandom);
               g  = 1'($urandom);
            end
         endcase
         write_cell_config(w, h, cm, g);
         random_phase(PhaseBeats);
         drain();
      end

      $display("Covered %0d input beats and %0d run descriptors over %0d cell settings",
               sb.beats_in, sb.runs_out, cell_settings);
      $display("Settings ranged from 1x1 to 4096x4096, both line orders, glow, bad sizes");
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
